// ----- rtl/core/ia64_pkg.sv -----
// Shared types, constants and the command decoder for the 64-bit integer ALU.
// Used by every module under rtl/core; depends on nothing else.
package ia64_pkg;

    localparam int OPERAND_W      = 64;
    localparam int CMD_W          = 5;
    localparam int DATA_WIDTH_DEF = 64;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int SHAMT_W        = 6;
    localparam int FUNC_W         = 4;

    localparam logic [CMD_W-1:0] CMD_ADD  = 5'd0;
    localparam logic [CMD_W-1:0] CMD_SUB  = 5'd1;
    localparam logic [CMD_W-1:0] CMD_MUL  = 5'd2;
    localparam logic [CMD_W-1:0] CMD_SDIV = 5'd3;
    localparam logic [CMD_W-1:0] CMD_SREM = 5'd4;
    localparam logic [CMD_W-1:0] CMD_UDIV = 5'd5;
    localparam logic [CMD_W-1:0] CMD_UREM = 5'd6;
    localparam logic [CMD_W-1:0] CMD_AND  = 5'd7;
    localparam logic [CMD_W-1:0] CMD_OR   = 5'd8;
    localparam logic [CMD_W-1:0] CMD_XOR  = 5'd9;
    localparam logic [CMD_W-1:0] CMD_SHL  = 5'd10;
    localparam logic [CMD_W-1:0] CMD_LSR  = 5'd11;
    localparam logic [CMD_W-1:0] CMD_ASR  = 5'd12;
    localparam logic [CMD_W-1:0] CMD_SLT  = 5'd13;
    localparam logic [CMD_W-1:0] CMD_SLE  = 5'd14;
    localparam logic [CMD_W-1:0] CMD_ULT  = 5'd15;
    localparam logic [CMD_W-1:0] CMD_ULE  = 5'd16;
    localparam logic [CMD_W-1:0] CMD_EQ   = 5'd17;

    localparam logic [FUNC_W-1:0] FN_ZERO = 4'd0;
    localparam logic [FUNC_W-1:0] FN_ADD  = 4'd1;
    localparam logic [FUNC_W-1:0] FN_SUB  = 4'd2;
    localparam logic [FUNC_W-1:0] FN_MUL  = 4'd3;
    localparam logic [FUNC_W-1:0] FN_AND  = 4'd4;
    localparam logic [FUNC_W-1:0] FN_OR   = 4'd5;
    localparam logic [FUNC_W-1:0] FN_XOR  = 4'd6;
    localparam logic [FUNC_W-1:0] FN_SHL  = 4'd7;
    localparam logic [FUNC_W-1:0] FN_LSR  = 4'd8;
    localparam logic [FUNC_W-1:0] FN_ASR  = 4'd9;
    localparam logic [FUNC_W-1:0] FN_SLT  = 4'd10;
    localparam logic [FUNC_W-1:0] FN_SLE  = 4'd11;
    localparam logic [FUNC_W-1:0] FN_ULT  = 4'd12;
    localparam logic [FUNC_W-1:0] FN_ULE  = 4'd13;
    localparam logic [FUNC_W-1:0] FN_EQ   = 4'd14;

    // Operation class produced by the front end.
    typedef struct packed {
        logic              is_div;
        logic              is_signed;
        logic              want_rem;
        logic [FUNC_W-1:0] func;
    } cls_t;

    // Control that travels alongside an item through the divider.
    typedef struct packed {
        logic is_div;
        logic want_rem;
        logic neg_q;
        logic neg_r;
        logic div_zero;
    } side_t;

    function automatic cls_t decode_cmd(input logic [CMD_W-1:0] cmd);
        cls_t c;
        c = '{is_div: 1'b0, is_signed: 1'b0, want_rem: 1'b0, func: FN_ZERO};
        case (cmd)
            CMD_ADD:  c.func = FN_ADD;
            CMD_SUB:  c.func = FN_SUB;
            CMD_MUL:  c.func = FN_MUL;
            CMD_SDIV: begin c.is_div = 1'b1; c.is_signed = 1'b1; end
            CMD_SREM: begin c.is_div = 1'b1; c.is_signed = 1'b1; c.want_rem = 1'b1; end
            CMD_UDIV: c.is_div = 1'b1;
            CMD_UREM: begin c.is_div = 1'b1; c.want_rem = 1'b1; end
            CMD_AND:  c.func = FN_AND;
            CMD_OR:   c.func = FN_OR;
            CMD_XOR:  c.func = FN_XOR;
            CMD_SHL:  c.func = FN_SHL;
            CMD_LSR:  c.func = FN_LSR;
            CMD_ASR:  c.func = FN_ASR;
            CMD_SLT:  c.func = FN_SLT;
            CMD_SLE:  c.func = FN_SLE;
            CMD_ULT:  c.func = FN_ULT;
            CMD_ULE:  c.func = FN_ULE;
            CMD_EQ:   c.func = FN_EQ;
            default:  c.func = FN_ZERO;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/integer_alu_64.sv -----
// Top level of the 64-bit integer ALU with pipelined multiply and divide.
// Depends on ia64_pkg, ia64_front and ia64_back.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_command, s_left_operand, s_right_operand
//   m_        out        m_valid/m_ready    m_answer, m_status
//
// One beat is accepted per cycle while the queue has room. Items pass the operand and
// multiply stages, the divider (one quotient bit per stage) and the result register.
// Every operation takes the same path, so results leave in order.
// Reset is synchronous and active low; it clears the queue and all valid bits.
// A stalled output freezes the back end; the queue keeps taking beats until full.
module integer_alu_64 #(
    parameter int DATA_WIDTH  = ia64_pkg::DATA_WIDTH_DEF,
    parameter int QUEUE_DEPTH = ia64_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ia64_pkg::CMD_W-1:0]     s_command,
    input  logic [ia64_pkg::OPERAND_W-1:0] s_left_operand,
    input  logic [ia64_pkg::OPERAND_W-1:0] s_right_operand,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ia64_pkg::OPERAND_W-1:0] m_answer,
    output logic                           m_status
);
    import ia64_pkg::*;

    logic                  q_valid;
    logic                  q_pop;
    cls_t                  q_cls;
    logic [DATA_WIDTH-1:0] q_left;
    logic [DATA_WIDTH-1:0] q_right;

    ia64_front #(
        .DATA_WIDTH  (DATA_WIDTH),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_left_operand  (s_left_operand),
        .s_right_operand (s_right_operand),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .q_cls           (q_cls),
        .q_left          (q_left),
        .q_right         (q_right)
    );

    ia64_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cls    (q_cls),
        .q_left   (q_left),
        .q_right  (q_right),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_answer (m_answer),
        .m_status (m_status)
    );

endmodule

// ----- rtl/core/ia64_front.sv -----
// Front end: accepts input beats, decodes the command and queues the item.
// Depends on ia64_pkg.
module ia64_front #(
    parameter int DATA_WIDTH  = ia64_pkg::DATA_WIDTH_DEF,
    parameter int QUEUE_DEPTH = ia64_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ia64_pkg::CMD_W-1:0]      s_command,
    input  logic [ia64_pkg::OPERAND_W-1:0]  s_left_operand,
    input  logic [ia64_pkg::OPERAND_W-1:0]  s_right_operand,
    output logic                            q_valid,
    input  logic                            q_pop,
    output ia64_pkg::cls_t                  q_cls,
    output logic [DATA_WIDTH-1:0]           q_left,
    output logic [DATA_WIDTH-1:0]           q_right
);
    import ia64_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cls_t                  cls_mem   [QUEUE_DEPTH];
    logic [DATA_WIDTH-1:0] left_mem  [QUEUE_DEPTH];
    logic [DATA_WIDTH-1:0] right_mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign s_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    assign q_cls   = cls_mem[rd_ptr_reg];
    assign q_left  = left_mem[rd_ptr_reg];
    assign q_right = right_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            cls_mem[wr_ptr_reg]   <= decode_cmd(s_command);
            left_mem[wr_ptr_reg]  <= s_left_operand[DATA_WIDTH-1:0];
            right_mem[wr_ptr_reg] <= s_right_operand[DATA_WIDTH-1:0];
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

// ----- rtl/core/ia64_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// Depends on ia64_pkg.
module ia64_divider #(
    parameter int DATA_WIDTH = ia64_pkg::DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  ia64_pkg::side_t       in_side,
    input  logic [DATA_WIDTH-1:0] in_res,
    input  logic [DATA_WIDTH-1:0] in_dividend,
    input  logic [DATA_WIDTH-1:0] in_divisor,
    output logic                  out_valid,
    output ia64_pkg::side_t       out_side,
    output logic [DATA_WIDTH-1:0] out_res,
    output logic [DATA_WIDTH-1:0] out_quo,
    output logic [DATA_WIDTH-1:0] out_rem
);
    import ia64_pkg::*;

    logic                  valid_w [DATA_WIDTH+1];
    side_t                 side_w  [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] res_w   [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] rem_w   [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] quo_w   [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] dvs_w   [DATA_WIDTH+1];

    assign valid_w[0] = in_valid;
    assign side_w[0]  = in_side;
    assign res_w[0]   = in_res;
    assign rem_w[0]   = '0;
    assign quo_w[0]   = in_dividend;
    assign dvs_w[0]   = in_divisor;

    for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_stage
        logic                  valid_reg;
        side_t                 side_reg;
        logic [DATA_WIDTH-1:0] res_reg, rem_reg, quo_reg, dvs_reg;
        logic [DATA_WIDTH:0]   trial, diff;
        logic                  ge;

        // The dividend shifts out at the top while quotient bits enter at the bottom.
        assign trial = {rem_w[i], quo_w[i][DATA_WIDTH-1]};
        assign diff  = trial - {1'b0, dvs_w[i]};
        assign ge    = (trial >= {1'b0, dvs_w[i]});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg <= 1'b0;
            end else if (adv) begin
                valid_reg <= valid_w[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                side_reg <= side_w[i];
                res_reg  <= res_w[i];
                dvs_reg  <= dvs_w[i];
                rem_reg  <= ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
                quo_reg  <= {quo_w[i][DATA_WIDTH-2:0], ge};
            end
        end

        assign valid_w[i+1] = valid_reg;
        assign side_w[i+1]  = side_reg;
        assign res_w[i+1]   = res_reg;
        assign rem_w[i+1]   = rem_reg;
        assign quo_w[i+1]   = quo_reg;
        assign dvs_w[i+1]   = dvs_reg;
    end

    assign out_valid = valid_w[DATA_WIDTH];
    assign out_side  = side_w[DATA_WIDTH];
    assign out_res   = res_w[DATA_WIDTH];
    assign out_quo   = quo_w[DATA_WIDTH];
    assign out_rem   = rem_w[DATA_WIDTH];

endmodule

// ----- rtl/core/ia64_back.sv -----
// Back end: operand stage, multiply stage, divider pipeline and result register.
// Depends on ia64_pkg and ia64_divider.
module ia64_back #(
    parameter int DATA_WIDTH = ia64_pkg::DATA_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_pop,
    input  ia64_pkg::cls_t                 q_cls,
    input  logic [DATA_WIDTH-1:0]          q_left,
    input  logic [DATA_WIDTH-1:0]          q_right,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ia64_pkg::OPERAND_W-1:0] m_answer,
    output logic                           m_status
);
    import ia64_pkg::*;

    localparam int LO_W = (DATA_WIDTH + 1) / 2;
    localparam int HI_W = DATA_WIDTH - LO_W;

    logic adv;

    // Operand stage signals.
    logic                  a_neg, b_neg;
    logic [SHAMT_W-1:0]    amt;
    logic [DATA_WIDTH-1:0] simple_res;
    side_t                 side_next;

    logic                  s1_valid_reg;
    logic                  s1_is_mul_reg;
    logic [DATA_WIDTH-1:0] s1_res_reg, s1_amag_reg, s1_bmag_reg;
    logic [2*LO_W-1:0]     s1_ll_reg;
    logic [HI_W-1:0]       s1_lh_reg, s1_hl_reg;
    side_t                 s1_side_reg;

    logic                  s2_valid_reg;
    logic [DATA_WIDTH-1:0] s2_res_reg, s2_amag_reg, s2_bmag_reg;
    side_t                 s2_side_reg;
    logic [DATA_WIDTH-1:0] mul_sum;

    logic                  d_valid;
    side_t                 d_side;
    logic [DATA_WIDTH-1:0] d_res, d_quo, d_rem;
    logic [DATA_WIDTH-1:0] fin_val, fin_mag, answer_next;
    logic                  fin_neg;

    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] out_answer_reg;
    logic                  out_status_reg;

    // The whole pipe moves together; it freezes only when the result register is held.
    assign adv   = !out_valid_reg || m_ready;
    assign q_pop = adv && q_valid;

    assign amt   = q_right[SHAMT_W-1:0];
    assign a_neg = q_cls.is_signed && q_left[DATA_WIDTH-1];
    assign b_neg = q_cls.is_signed && q_right[DATA_WIDTH-1];

    always_comb begin
        case (q_cls.func)
            FN_ADD:  simple_res = q_left + q_right;
            FN_SUB:  simple_res = q_left - q_right;
            FN_AND:  simple_res = q_left & q_right;
            FN_OR:   simple_res = q_left | q_right;
            FN_XOR:  simple_res = q_left ^ q_right;
            FN_SHL:  simple_res = q_left << amt;
            FN_LSR:  simple_res = q_left >> amt;
            FN_ASR:  simple_res = DATA_WIDTH'($signed(q_left) >>> amt);
            FN_SLT:  simple_res = DATA_WIDTH'($signed(q_left) < $signed(q_right));
            FN_SLE:  simple_res = DATA_WIDTH'($signed(q_left) <= $signed(q_right));
            FN_ULT:  simple_res = DATA_WIDTH'(q_left < q_right);
            FN_ULE:  simple_res = DATA_WIDTH'(q_left <= q_right);
            FN_EQ:   simple_res = DATA_WIDTH'(q_left == q_right);
            default: simple_res = '0;
        endcase
    end

    always_comb begin
        side_next.is_div   = q_cls.is_div;
        side_next.want_rem = q_cls.want_rem;
        side_next.neg_q    = a_neg ^ b_neg;
        side_next.neg_r    = a_neg;
        side_next.div_zero = (q_right == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= d_valid;
        end
    end

    // Operand stage: simple operations, magnitudes and the partial products.
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_res_reg    <= simple_res;
            s1_is_mul_reg <= (q_cls.func == FN_MUL);
            s1_amag_reg   <= a_neg ? '0 - q_left : q_left;
            s1_bmag_reg   <= b_neg ? '0 - q_right : q_right;
            s1_ll_reg     <= q_left[LO_W-1:0] * q_right[LO_W-1:0];
            s1_lh_reg     <= HI_W'(q_left[LO_W-1:0] * q_right[DATA_WIDTH-1:LO_W]);
            s1_hl_reg     <= HI_W'(q_left[DATA_WIDTH-1:LO_W] * q_right[LO_W-1:0]);
            s1_side_reg   <= side_next;
        end
    end

    assign mul_sum = DATA_WIDTH'(s1_ll_reg)
                   + {HI_W'(s1_lh_reg + s1_hl_reg), {LO_W{1'b0}}};

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_res_reg  <= s1_is_mul_reg ? mul_sum : s1_res_reg;
            s2_amag_reg <= s1_amag_reg;
            s2_bmag_reg <= s1_bmag_reg;
            s2_side_reg <= s1_side_reg;
        end
    end

    ia64_divider #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_divider (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .in_valid    (s2_valid_reg),
        .in_side     (s2_side_reg),
        .in_res      (s2_res_reg),
        .in_dividend (s2_amag_reg),
        .in_divisor  (s2_bmag_reg),
        .out_valid   (d_valid),
        .out_side    (d_side),
        .out_res     (d_res),
        .out_quo     (d_quo),
        .out_rem     (d_rem)
    );

    assign fin_val = d_side.want_rem ? d_rem : d_quo;
    assign fin_neg = d_side.want_rem ? d_side.neg_r : d_side.neg_q;
    assign fin_mag = fin_neg ? '0 - fin_val : fin_val;

    always_comb begin
        if (!d_side.is_div) begin
            answer_next = d_res;
        end else if (d_side.div_zero) begin
            answer_next = '0;
        end else begin
            answer_next = fin_mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_answer_reg <= answer_next;
            out_status_reg <= d_side.is_div && d_side.div_zero;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_answer = OPERAND_W'(out_answer_reg);
    assign m_status = out_status_reg;

    a_zero_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_answer == '0))
        else $error("error status with non-zero answer");

    a_stage_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> (s2_valid_reg == $past(s1_valid_reg)))
        else $error("multiply stage lost or duplicated a beat");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> out_valid_reg)
        else $error("held result dropped during stall");

endmodule
